FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the translator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tlbpt_pkg.sv
// Package for the TLB and page-table translator: controller state type.
// No dependencies.
`timescale 1ns / 1ps

package tlbpt_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_MISS  = 3'b100
  } state_t;

endpackage

FILE: sv/tlbpt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tlb_page_table_translator_unit.sv
// Top level of the TLB and page-table address translator.
// Depends on tlbpt_pkg, tlbpt_ram and assert_macros.svh.
//
//  Channel  Ports                                   Handshake
//  -------  --------------------------------------  -----------------------------
//  request  in_logical_address                      start high and busy low
//  result   out_physical_address, out_tlb_hit,      out_valid high for one cycle
//           out_page_fault
//
// A TLB hit is answered from the registered outputs: the result appears the cycle after
// the request and busy stays low. A miss passes through ST_MISS, with busy high,
// for the registered read of the page-table RAM and, for an unmapped page, its write-back.
// After reset the page-table RAM is swept clear, one entry a cycle, through all PAGE_COUNT
// entries; busy is high meanwhile. The receiver cannot stall.
// Page and frame sizes must be powers of two; the block itself does not check this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlb_page_table_translator_unit #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int PAGE_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_logical_address,
  output logic        out_valid,
  output logic [15:0] out_physical_address,
  output logic        out_tlb_hit,
  output logic        out_page_fault
);

  localparam int TLB_IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int NF_W   = $clog2(PAGE_COUNT + 1);
  localparam int PT_W   = PAGE_W + 1;

  tlbpt_pkg::state_t state_r, state_nxt;

  logic [PAGE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TLB_IW-1:0] ptr_r, ptr_nxt;
  logic [NF_W-1:0]   nf_r, nf_nxt;
  logic [PAGE_W-1:0] page_r;
  logic [OFF_W-1:0]  off_r;

  logic [PAGE_W-1:0] tag_r [TLB_ENTRIES];
  logic [PAGE_W-1:0] frm_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] vld_r;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pa_r, out_pa_nxt;
  logic        out_hit_r, out_hit_nxt;
  logic        out_fault_r, out_fault_nxt;

  logic [OFF_W+PAGE_W+15:0] addr_ext;
  logic [PAGE_W-1:0]        in_page;
  logic [OFF_W-1:0]         in_off;
  logic [TLB_ENTRIES-1:0]   match;
  logic [PAGE_W-1:0]        hit_frame;
  logic                     tlb_hit;

  logic              pt_we;
  logic [PAGE_W-1:0] pt_waddr;
  logic [PT_W-1:0]   pt_wdata;
  logic [PT_W-1:0]   pt_rdata;
  logic              pt_mapped;
  logic [PAGE_W-1:0] new_frame;
  logic [PAGE_W-1:0] miss_frame;
  logic              tlb_we;
  logic [PAGE_W+OFF_W+15:0] hit_pa_ext;
  logic [PAGE_W+OFF_W+15:0] miss_pa_ext;

  assign addr_ext = {{(OFF_W + PAGE_W){1'b0}}, in_logical_address};
  assign in_page  = addr_ext[OFF_W +: PAGE_W];
  assign in_off   = addr_ext[OFF_W-1:0];

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = vld_r[i] && (tag_r[i] == in_page);
      if (match[i]) begin
        hit_frame = hit_frame | frm_r[i];
      end
    end
  end

  assign tlb_hit = |match;

  tlbpt_ram #(
    .WIDTH (PT_W),
    .DEPTH (PAGE_COUNT)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (in_page),
    .rdata (pt_rdata)
  );

  assign pt_mapped  = pt_rdata[PAGE_W];
  assign new_frame  = (nf_r >= NF_W'(PAGE_COUNT)) ? PAGE_W'(PAGE_COUNT - 1)
                                                  : nf_r[PAGE_W-1:0];
  assign miss_frame = pt_mapped ? pt_rdata[PAGE_W-1:0] : new_frame;

  assign hit_pa_ext  = {16'b0, hit_frame, in_off};
  assign miss_pa_ext = {16'b0, miss_frame, off_r};

  assign busy   = (state_r != tlbpt_pkg::ST_IDLE);
  assign tlb_we = (state_r == tlbpt_pkg::ST_MISS);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ptr_nxt       = ptr_r;
    nf_nxt        = nf_r;
    out_valid_nxt = 1'b0;
    out_pa_nxt    = out_pa_r;
    out_hit_nxt   = out_hit_r;
    out_fault_nxt = out_fault_r;
    pt_we         = 1'b0;
    pt_waddr      = page_r;
    pt_wdata      = {1'b1, new_frame};
    unique case (state_r)
      tlbpt_pkg::ST_CLEAR: begin
        pt_we       = 1'b1;
        pt_waddr    = clr_cnt_r;
        pt_wdata    = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == PAGE_W'(PAGE_COUNT - 1)) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      tlbpt_pkg::ST_IDLE: begin
        if (start) begin
          if (tlb_hit) begin
            out_valid_nxt = 1'b1;
            out_pa_nxt    = hit_pa_ext[15:0];
            out_hit_nxt   = 1'b1;
            out_fault_nxt = 1'b0;
          end else begin
            state_nxt = tlbpt_pkg::ST_MISS;
          end
        end
      end
      tlbpt_pkg::ST_MISS: begin
        pt_we         = !pt_mapped;
        out_valid_nxt = 1'b1;
        out_pa_nxt    = miss_pa_ext[15:0];
        out_hit_nxt   = 1'b0;
        out_fault_nxt = !pt_mapped;
        if (!pt_mapped && (nf_r < NF_W'(PAGE_COUNT))) begin
          nf_nxt = nf_r + 1'b1;
        end
        ptr_nxt   = (ptr_r == TLB_IW'(TLB_ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
        state_nxt = tlbpt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tlbpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlbpt_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      ptr_r       <= '0;
      nf_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ptr_r       <= ptr_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
      if (tlb_we) begin
        vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_pa_r    <= out_pa_nxt;
    out_hit_r   <= out_hit_nxt;
    out_fault_r <= out_fault_nxt;
    if ((state_r == tlbpt_pkg::ST_IDLE) && start) begin
      page_r <= in_page;
      off_r  <= in_off;
    end
    if (tlb_we) begin
      tag_r[ptr_r] <= page_r;
      frm_r[ptr_r] <= miss_frame;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;

  `ASSERT_NEXT(a_req_answered, clk, rst_n, start && !busy, out_valid || busy,
    "Accepted request produced neither a result nor a miss cycle.")
  `ASSERT_NEXT(a_miss_result, clk, rst_n, state_r == tlbpt_pkg::ST_MISS,
    out_valid && !out_tlb_hit && !busy, "Miss cycle did not deliver a miss result.")
  `ASSERT_SAME(a_hit_no_fault, clk, rst_n, out_valid && out_tlb_hit, !out_page_fault,
    "TLB hit reported together with a page fault.")
  `ASSERT_SAME(a_free_frame_bound, clk, rst_n, 1'b1, nf_r <= NF_W'(PAGE_COUNT),
    "Free-frame counter ran past the page count.")

endmodule

FILE: bench/tlb_translation_checker.sv
// Checker for the TLB and page-table translator: watches the request and result ports,
// predicts each translation and compares the results field by field.
// No dependencies; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module tlb_translation_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_logical_address,
  input  logic        out_valid,
  input  logic [15:0] out_physical_address,
  input  logic        out_tlb_hit,
  input  logic        out_page_fault,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          hit_count,
  output int          fault_count
);

  localparam int TlbEntries = 16;
  localparam int PageCount  = 256;

  typedef struct packed {
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        page_fault;
  } translation_t;

  logic [7:0] tlb_tag   [TlbEntries];
  logic [7:0] tlb_frame [TlbEntries];
  logic       tlb_valid [TlbEntries];
  logic [3:0] tlb_next_slot;
  logic [7:0] pt_frame  [PageCount];
  logic       pt_mapped [PageCount];
  logic [8:0] free_frame;

  translation_t expected_translations[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_count  = 0;
    hit_count     = 0;
    fault_count   = 0;
  end

  function automatic translation_t translate(input logic [15:0] la);
    logic [7:0]   page;
    logic [7:0]   frame;
    translation_t t;
    page  = la[15:8];
    frame = '0;
    t     = '0;
    for (int i = 0; i < TlbEntries; i++) begin
      if (!t.tlb_hit && tlb_valid[i] && tlb_tag[i] == page) begin
        frame     = tlb_frame[i];
        t.tlb_hit = 1'b1;
      end
    end
    if (!t.tlb_hit) begin
      if (!pt_mapped[page]) begin
        if (free_frame >= PageCount) begin
          pt_frame[page] = 8'(PageCount - 1);
        end else begin
          pt_frame[page] = free_frame[7:0];
          free_frame     = free_frame + 9'd1;
        end
        pt_mapped[page] = 1'b1;
        t.page_fault    = 1'b1;
      end
      frame                    = pt_frame[page];
      tlb_tag[tlb_next_slot]   = page;
      tlb_frame[tlb_next_slot] = frame;
      tlb_valid[tlb_next_slot] = 1'b1;
      tlb_next_slot            = tlb_next_slot + 4'd1;
    end
    t.physical_address = {frame, la[7:0]};
    return t;
  endfunction

  always @(posedge clk) begin : monitor
    translation_t want;
    int           errors;
    errors = 0;
    if (!rst_n) begin
      for (int i = 0; i < TlbEntries; i++) begin
        tlb_valid[i] = 1'b0;
      end
      for (int p = 0; p < PageCount; p++) begin
        pt_mapped[p] = 1'b0;
      end
      tlb_next_slot = '0;
      free_frame    = '0;
      expected_translations.delete();
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        hit_count    <= hit_count + int'(out_tlb_hit);
        fault_count  <= fault_count + int'(out_page_fault);
        if (expected_translations.size() == 0) begin
          $error("Result with no request outstanding: physical_address %h", out_physical_address);
          errors++;
        end else begin
          want = expected_translations.pop_front();
          if (out_physical_address !== want.physical_address) begin
            $error("physical_address mismatch: expected %h, actual %h",
                   want.physical_address, out_physical_address);
            errors++;
          end
          if (out_tlb_hit !== want.tlb_hit) begin
            $error("tlb_hit mismatch: expected %b, actual %b", want.tlb_hit, out_tlb_hit);
            errors++;
          end
          if (out_page_fault !== want.page_fault) begin
            $error("page_fault mismatch: expected %b, actual %b", want.page_fault, out_page_fault);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        expected_translations.push_back(translate(in_logical_address));
      end
    end
    fail_count    <= fail_count + errors;
    pending_count <= expected_translations.size();
  end

endmodule

FILE: bench/tb_top.sv
// Top of the translator testbench: clock, reset, request stimulus and the verdict.
// Depends on tlb_page_table_translator_unit and tlb_translation_checker.
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_logical_address;
  logic        out_valid;
  logic [15:0] out_physical_address;
  logic        out_tlb_hit;
  logic        out_page_fault;

  int fail_count;
  int pending_count;
  int result_count;
  int hit_count;
  int fault_count;

  tlb_page_table_translator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_logical_address  (in_logical_address),
    .out_valid           (out_valid),
    .out_physical_address(out_physical_address),
    .out_tlb_hit         (out_tlb_hit),
    .out_page_fault      (out_page_fault)
  );

  tlb_translation_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_logical_address  (in_logical_address),
    .out_valid           (out_valid),
    .out_physical_address(out_physical_address),
    .out_tlb_hit         (out_tlb_hit),
    .out_page_fault      (out_page_fault),
    .fail_count          (fail_count),
    .pending_count       (pending_count),
    .result_count        (result_count),
    .hit_count           (hit_count),
    .fault_count         (fault_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Start stays high from one request to the next; only an idle burst or the end of the stimulus lowers it.
  task automatic issue_request(input logic [15:0] la);
    start              <= 1'b1;
    in_logical_address <= la;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] directed_addrs[$];
    logic [7:0]  hot_pages[8];
    logic [7:0]  warm_pages[32];
    logic [7:0]  page;
    logic [7:0]  offset;
    int          pick;
    int          random_requests;
    directed_addrs     = '{16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'h5AA5, 16'hA55A};
    random_requests    = 1525;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_logical_address = '0;
    foreach (hot_pages[i]) hot_pages[i] = 8'($urandom_range(255));
    foreach (warm_pages[i]) warm_pages[i] = 8'($urandom_range(255));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_addrs[i]) issue_request(directed_addrs[i]);
    // Sixteen fresh pages push every earlier page out of the TLB.
    for (int p = 1; p <= 16; p++) begin
      issue_request({8'(p), 8'($urandom_range(255))});
    end
    issue_request(16'h0012);
    issue_request(16'hFF34);
    issue_request(16'h0011);

    for (int n = 0; n < random_requests; n++) begin
      if (n < random_requests - 150 && (n / 120) % 3 != 2 && $urandom_range(3) == 0) begin
        idle_burst();
      end
      if ($urandom_range(49) == 0) hot_pages[$urandom_range(7)] = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 55) page = hot_pages[$urandom_range(7)];
      else if (pick < 80) page = warm_pages[$urandom_range(31)];
      else page = 8'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick == 0) offset = 8'h00;
      else if (pick == 1) offset = 8'hFF;
      else offset = 8'($urandom_range(255));
      issue_request({page, offset});
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d translations: %0d TLB hits, %0d page faults, %0d misses on mapped pages.",
             result_count, hit_count, fault_count, result_count - hit_count - fault_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #500000;
    $display("Run timed out with %0d requests outstanding.", pending_count);
    $display("Test completed with failures");
    $finish;
  end

endmodule
